// ===== hw/rtl/vid_pkg.sv =====
package vid_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int SLOT_W = $clog2(TABLE_DEPTH);
	localparam int COUNT_W = SLOT_W + 1;
	localparam int ATTR_W = 24;
	localparam int VIDX_W = 12;
	localparam int EPOCH_W = 8;
	localparam int HASH_W = 32;
	localparam int HASH_FOLD = 15;

	localparam logic [HASH_W-1:0] HASH_MUL_P = 32'h9E37_79B1;
	localparam logic [HASH_W-1:0] HASH_MUL_U = 32'h85EB_CA77;
	localparam logic [HASH_W-1:0] HASH_MUL_N = 32'hC2B2_AE3D;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_USES_UV = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_USES_NORMAL = 1'd1;

	typedef struct packed {
		logic [ATTR_W-1:0] position_index;
		logic [ATTR_W-1:0] uv_index;
		logic [ATTR_W-1:0] normal_index;
		logic              first_of_mesh;
	} in_item_t;

	typedef struct packed {
		logic [VIDX_W-1:0] vertex_index;
		logic              is_new;
		logic              overflow;
	} out_item_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [ATTR_W-1:0]  position;
		logic [ATTR_W-1:0]  uv;
		logic [ATTR_W-1:0]  normal;
		logic [SLOT_W-1:0]  vid;
	} row_t;

	typedef struct packed {
		logic load;
		logic new_mesh;
		logic clr_start;
		logic clr_step;
		logic clr_done;
		logic hash;
		logic rd;
		logic step;
		logic ins;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic epoch_last;
		logic clr_last;
		logic row_valid;
		logic row_match;
		logic probe_last;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== hw/rtl/vertex_index_dedup.sv =====
// Face-corner deduplication: each input beat carries a position, uv and normal index and
// returns one output beat with the vertex index of that key, is_new when the index was just
// assigned, or overflow when the key is absent and all 4096 table slots are used. An item
// whose key is found or inserted at its first probed slot passes the hash, read and compare
// states to the output register, and the next item is taken only after that; each further
// probe adds one table read and one compare, since the key table has a single read port, so
// a miss on a full table probes all 4096 slots. The block takes the next item while a result
// still waits to be taken. After reset, and on every 255th item flagged first_of_mesh, all
// 4096 table slots are swept before further items are taken; configuration writes are taken
// at any time but are meant to be issued while the block is idle.
module vertex_index_dedup (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vid_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vid_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  vid_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output vid_pkg::out_item_t              out_data
);

	vid_pkg::ctl_cmd_t cmd;
	vid_pkg::dp_stat_t stat;

	vid_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.first_of_mesh (in_data.first_of_mesh),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.stat          (stat)
	);

	vid_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ===== hw/rtl/vid_ctrl.sv =====
module vid_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                first_of_mesh,
	output logic                in_stall,
	output vid_pkg::ctl_cmd_t   cmd,
	input  vid_pkg::dp_stat_t   stat
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_HASH  = 5'b00010,
		S_READ  = 5'b00100,
		S_CMP   = 5'b01000,
		S_CLEAR = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   pend_q, pend_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pend_d   = pend_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_HASH;
					if (first_of_mesh) begin
						cmd.new_mesh = 1'b1;
						if (stat.epoch_last) begin
							cmd.clr_start = 1'b1;
							pend_d        = 1'b1;
							state_d       = S_CLEAR;
						end
					end
				end
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					cmd.clr_done = 1'b1;
					pend_d       = 1'b0;
					state_d      = pend_q ? S_HASH : S_IDLE;
				end
			end
			S_HASH: begin
				cmd.hash = 1'b1;
				state_d  = S_READ;
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (!stat.row_valid || stat.row_match || stat.probe_last) begin
					if (stat.out_free) begin
						cmd.out_load = 1'b1;
						cmd.ins      = !stat.row_valid;
						state_d      = S_IDLE;
					end
				end else begin
					cmd.step = 1'b1;
					state_d  = S_READ;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/vid_dp.sv =====
module vid_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vid_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vid_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  vid_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output vid_pkg::out_item_t              out_data,
	input  vid_pkg::ctl_cmd_t               cmd,
	output vid_pkg::dp_stat_t               stat
);

	logic                            cfg_uv_q;
	logic                            cfg_nrm_q;
	logic [vid_pkg::ATTR_W-1:0]      pos_q;
	logic [vid_pkg::ATTR_W-1:0]      uv_q;
	logic [vid_pkg::ATTR_W-1:0]      nrm_q;
	logic [vid_pkg::EPOCH_W-1:0]     cur_epoch_q;
	logic [vid_pkg::COUNT_W-1:0]     count_q;
	logic [vid_pkg::SLOT_W-1:0]      slot_q;
	logic [vid_pkg::SLOT_W-1:0]      probe_q;
	logic                            out_valid_q;
	vid_pkg::out_item_t              out_q;
	vid_pkg::row_t                   rd_row_q;
	vid_pkg::row_t                   mem [vid_pkg::TABLE_DEPTH];
	vid_pkg::row_t                   wr_row;
	vid_pkg::out_item_t              res;
	logic                            mem_we;
	logic [vid_pkg::HASH_W-1:0]      hash_mix;
	logic [vid_pkg::HASH_W-1:0]      hash_fold;
	logic                            row_valid;
	logic                            row_match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_uv_q  <= 1'b1;
			cfg_nrm_q <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == vid_pkg::CFG_KEY_USES_UV) begin
				cfg_uv_q <= cfg_data[0];
			end else if (cfg_index == vid_pkg::CFG_KEY_USES_NORMAL) begin
				cfg_nrm_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q <= in_data.position_index;
			uv_q  <= cfg_uv_q ? in_data.uv_index : '0;
			nrm_q <= cfg_nrm_q ? in_data.normal_index : '0;
		end
	end

	always_comb begin
		hash_mix = (vid_pkg::HASH_W'(pos_q) * vid_pkg::HASH_MUL_P)
		         ^ (vid_pkg::HASH_W'(uv_q) * vid_pkg::HASH_MUL_U)
		         ^ (vid_pkg::HASH_W'(nrm_q) * vid_pkg::HASH_MUL_N);
		hash_fold = hash_mix ^ (hash_mix >> vid_pkg::HASH_FOLD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_epoch_q <= vid_pkg::EPOCH_W'(1);
			count_q     <= '0;
			slot_q      <= '0;
			probe_q     <= '0;
		end else begin
			if (cmd.new_mesh) begin
				count_q <= '0;
				if (!stat.epoch_last) begin
					cur_epoch_q <= cur_epoch_q + vid_pkg::EPOCH_W'(1);
				end
			end else if (cmd.ins) begin
				count_q <= count_q + vid_pkg::COUNT_W'(1);
			end
			if (cmd.clr_done) begin
				cur_epoch_q <= vid_pkg::EPOCH_W'(1);
			end
			if (cmd.clr_start) begin
				slot_q <= '0;
			end else if (cmd.hash) begin
				slot_q  <= hash_fold[vid_pkg::SLOT_W-1:0];
				probe_q <= '0;
			end else if (cmd.step) begin
				slot_q  <= slot_q + vid_pkg::SLOT_W'(1);
				probe_q <= probe_q + vid_pkg::SLOT_W'(1);
			end else if (cmd.clr_step) begin
				slot_q <= slot_q + vid_pkg::SLOT_W'(1);
			end
		end
	end

	always_comb begin
		mem_we = cmd.clr_step || cmd.ins;
		wr_row = '0;
		if (cmd.ins) begin
			wr_row.epoch    = cur_epoch_q;
			wr_row.position = pos_q;
			wr_row.uv       = uv_q;
			wr_row.normal   = nrm_q;
			wr_row.vid      = count_q[vid_pkg::SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot_q] <= wr_row;
		end
		if (cmd.rd) begin
			rd_row_q <= mem[slot_q];
		end
	end

	always_comb begin
		row_valid = rd_row_q.epoch == cur_epoch_q;
		row_match = row_valid && rd_row_q.position == pos_q
		         && rd_row_q.uv == uv_q && rd_row_q.normal == nrm_q;
		res = '0;
		if (!row_valid) begin
			res.vertex_index = vid_pkg::VIDX_W'(count_q);
			res.is_new       = 1'b1;
		end else if (row_match) begin
			res.vertex_index = vid_pkg::VIDX_W'(rd_row_q.vid);
		end else begin
			res.overflow = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stat.epoch_last = cur_epoch_q == '1;
	assign stat.clr_last   = slot_q == '1;
	assign stat.row_valid  = row_valid;
	assign stat.row_match  = row_match;
	assign stat.probe_last = probe_q == '1;
	assign stat.out_free   = !out_valid_q || !out_stall;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= vid_pkg::COUNT_W'(vid_pkg::TABLE_DEPTH))
		else $error("distinct count beyond table depth");

	a_epoch_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cur_epoch_q != '0)
		else $error("current epoch equals the cleared mark");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a beat not yet taken");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |-> (!row_valid && count_q < vid_pkg::COUNT_W'(vid_pkg::TABLE_DEPTH)))
		else $error("insert into a used row or a full table");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + vid_pkg::COUNT_W'(1))
		else $error("insert did not advance the vertex count");

endmodule
